// File: rtl/sps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// shared types and constants for the sparse set packed store
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int CAPACITY    = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int KEY_WIDTH   = 8;
  localparam int SLOT_WIDTH  = 8;
  localparam int COUNT_WIDTH = 9;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_ABSENT   = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_REPLACED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXEC,
    ST_FETCH,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [DATA_WIDTH-1:0]  data_out;
    logic [SLOT_WIDTH-1:0]  slot;
    logic [COUNT_WIDTH-1:0] count;
  } out_item_t;

endpackage

// File: rtl/sparse_set_packed_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_set_packed_store
// sparse set with swap remove, elements kept densely packed in slots
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid / in_ready / in_data (mode, key, data_in)
//   out channel : out_valid / out_ready / out_data (status, data_out, slot,
//                 count), one result per input transfer, in order
//   add, remove and a get that misses load the result register in the execute
//   state, a get that hits in the deliver state; the fetch and deliver states
//   are the dependent element read at the slot found in the key map. the three
//   rams (key map, slot map, element store) each have one registered read port,
//   which sets the sequence lookup -> execute (-> fetch -> deliver)
//   in_ready is high only in idle, so an item runs all its steps before the
//   next is taken, while the previous result may still wait in the output
//   register; if the receiver stalls, the block parks in its last step with
//   no ram write done until the output register frees up
//   reset: key presence bits and element count are cleared directly, no sweep;
//   slot map and element store are not cleared, only occupied slots are read
// ----------------------------------------------------------------------------
module sparse_set_packed_store
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  state_t state;
  state_t state_next;

  // captured request and working registers
  in_item_t               req;
  logic [SLOT_WIDTH-1:0]  slot_q;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [CAPACITY-1:0]    present;

  // result register control
  logic      out_free;
  logic      res_load;
  out_item_t res;

  // key map: key -> slot
  logic                   ks_we;
  logic [KEY_WIDTH-1:0]   ks_waddr;
  logic [SLOT_WIDTH-1:0]  ks_wdata;
  logic [SLOT_WIDTH-1:0]  ks_rdata;

  // slot map: slot -> key
  logic                   sk_we;
  logic [SLOT_WIDTH-1:0]  sk_waddr;
  logic [KEY_WIDTH-1:0]   sk_wdata;
  logic [KEY_WIDTH-1:0]   sk_rdata;

  // element store
  logic                   el_we;
  logic [SLOT_WIDTH-1:0]  el_waddr;
  logic [DATA_WIDTH-1:0]  el_wdata;
  logic [SLOT_WIDTH-1:0]  el_raddr;
  logic [DATA_WIDTH-1:0]  el_rdata;

  logic                   set_present;
  logic                   clr_present;
  logic                   hit;
  logic                   full;
  logic [SLOT_WIDTH-1:0]  last_idx;
  logic [COUNT_WIDTH-1:0] count_dec;

  assign out_free  = !out_valid || out_ready;
  assign hit       = present[req.key];
  assign full      = (count == COUNT_WIDTH'(CAPACITY));
  assign count_dec = count - COUNT_WIDTH'(1);
  // last occupied slot, only meaningful with a nonempty store
  assign last_idx  = count_dec[SLOT_WIDTH-1:0];

  sps_ram #(.WIDTH(SLOT_WIDTH), .DEPTH(CAPACITY)) u_key_map (
    .clk   (clk),
    .we    (ks_we),
    .waddr (ks_waddr),
    .wdata (ks_wdata),
    .raddr (req.key),
    .rdata (ks_rdata)
  );

  sps_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_slot_map (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (last_idx),
    .rdata (sk_rdata)
  );

  sps_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_elements (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        // a get that hits needs the element read at the found slot
        if (req.mode == MODE_GET && hit) begin
          state_next = ST_FETCH;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FETCH: begin
        state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs: ram accesses, result, count update
  always_comb begin
    in_ready    = (state == ST_IDLE);
    ks_we       = 1'b0;
    ks_waddr    = req.key;
    ks_wdata    = ks_rdata;
    sk_we       = 1'b0;
    sk_waddr    = ks_rdata;
    sk_wdata    = sk_rdata;
    el_we       = 1'b0;
    el_waddr    = ks_rdata;
    el_wdata    = req.data_in;
    el_raddr    = last_idx;
    set_present = 1'b0;
    clr_present = 1'b0;
    count_next  = count;
    res_load    = 1'b0;
    res         = '{status: STAT_ABSENT, data_out: '0, slot: '0, count: count};

    case (state)
      ST_EXEC: begin
        if (out_free && !(req.mode == MODE_GET && hit)) begin
          res_load = 1'b1;
          case (req.mode)
            MODE_ADD: begin
              if (hit) begin
                // overwrite in place, maps untouched
                el_we      = 1'b1;
                res.status = STAT_REPLACED;
                res.slot   = ks_rdata;
              end else if (!full) begin
                // append at the first free slot
                ks_we       = 1'b1;
                ks_wdata    = count[SLOT_WIDTH-1:0];
                sk_we       = 1'b1;
                sk_waddr    = count[SLOT_WIDTH-1:0];
                sk_wdata    = req.key;
                el_we       = 1'b1;
                el_waddr    = count[SLOT_WIDTH-1:0];
                set_present = 1'b1;
                count_next  = count + COUNT_WIDTH'(1);
                res.status  = STAT_OK;
                res.slot    = count[SLOT_WIDTH-1:0];
              end else begin
                res.status = STAT_FULL;
              end
            end
            MODE_REMOVE: begin
              if (hit) begin
                // swap remove: last element and its key move into the hole
                el_we       = 1'b1;
                el_wdata    = el_rdata;
                sk_we       = 1'b1;
                ks_we       = 1'b1;
                ks_waddr    = sk_rdata;
                clr_present = 1'b1;
                count_next  = count_dec;
                res.status  = STAT_OK;
                res.slot    = ks_rdata;
              end
            end
            default: begin
              // get miss and the unused mode answer absent
            end
          endcase
          res.count = count_next;
        end
      end
      ST_FETCH: begin
        el_raddr = slot_q;
      end
      ST_DELIVER: begin
        el_raddr = slot_q;
        if (out_free) begin
          res_load     = 1'b1;
          res.status   = STAT_OK;
          res.data_out = el_rdata;
          res.slot     = slot_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      present   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (set_present) begin
        present[req.key] <= 1'b1;
      end else if (clr_present) begin
        present[req.key] <= 1'b0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (state == ST_EXEC) begin
      slot_q <= ks_rdata;
    end
    if (res_load) begin
      out_data <= res;
    end
  end

endmodule

// File: rtl/sps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: dv/sps_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// watches both channels of the sparse set store, keeps its own copy of the
// key map, slot map, element store and count, and compares every result
// transfer field by field against the oldest predicted result
// ----------------------------------------------------------------------------
module sps_checker
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        results_due
);

  localparam int KEY_SPACE = 2 ** KEY_WIDTH;

  typedef struct {
    in_item_t  op;
    out_item_t want;
  } due_result_t;

  logic                   key_live   [KEY_SPACE];
  logic [SLOT_WIDTH-1:0]  key_slot   [KEY_SPACE];
  logic [KEY_WIDTH-1:0]   slot_owner [CAPACITY];
  logic [DATA_WIDTH-1:0]  elem       [CAPACITY];
  logic [COUNT_WIDTH-1:0] held;

  due_result_t due_q[$];
  int          fails;

  initial begin
    fails       = 0;
    held        = '0;
    foreach (key_live[k]) key_live[k] = 1'b0;
  end

  // apply one operation to the shadow set and return its result
  function automatic out_item_t set_op_result(in_item_t op);
    out_item_t             res;
    logic                  live;
    logic [SLOT_WIDTH-1:0] at;
    logic [SLOT_WIDTH-1:0] tail;
    logic [KEY_WIDTH-1:0]  tail_key;
    res  = '0;
    res.status = STAT_ABSENT;
    live = (int'(op.key) < CAPACITY) && key_live[op.key];
    case (mode_t'(op.mode))
      MODE_ADD: begin
        if (int'(op.key) >= CAPACITY) begin
          res.status = STAT_ABSENT;
        end else if (live) begin
          at = key_slot[op.key];
          elem[at] = op.data_in;
          res.status = STAT_REPLACED;
          res.slot   = at;
        end else if (int'(held) >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          at = held[SLOT_WIDTH-1:0];
          key_live[op.key] = 1'b1;
          key_slot[op.key] = at;
          slot_owner[at]   = op.key;
          elem[at]         = op.data_in;
          held             = held + 1'b1;
          res.status = STAT_OK;
          res.slot   = at;
        end
      end
      MODE_GET: begin
        if (live) begin
          at = key_slot[op.key];
          res.status   = STAT_OK;
          res.data_out = elem[at];
          res.slot     = at;
        end
      end
      MODE_REMOVE: begin
        if (live && held != 0) begin
          at       = key_slot[op.key];
          tail     = SLOT_WIDTH'(held - 1'b1);
          tail_key = slot_owner[tail];
          // swap the last element into the freed slot
          elem[at]           = elem[tail];
          slot_owner[at]     = tail_key;
          key_slot[tail_key] = at;
          key_live[op.key]   = 1'b0;
          key_slot[op.key]   = '0;
          held               = held - 1'b1;
          res.status = STAT_OK;
          res.slot   = at;
        end
      end
      default: res.status = STAT_ABSENT;
    endcase
    res.count = held;
    return res;
  endfunction

  always @(posedge clk) begin
    due_result_t head;
    if (rst) begin
      foreach (key_live[k]) key_live[k] = 1'b0;
      held = '0;
      due_q.delete();
    end else begin
      // results first, so a same-edge input never pairs with its own result
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          fails = fails + 1;
          if (fails <= 10)
            $display("%0t: unexpected result st=%0d data=%h slot=%0d cnt=%0d",
                     $realtime, out_data.status, out_data.data_out,
                     out_data.slot, out_data.count);
        end else begin
          head = due_q.pop_front();
          if (out_data.status !== head.want.status ||
              out_data.data_out !== head.want.data_out ||
              out_data.slot !== head.want.slot ||
              out_data.count !== head.want.count) begin
            fails = fails + 1;
            if (fails <= 10)
              $display({"%0t: mode %0d key %0d: exp st=%0d data=%h slot=%0d cnt=%0d,",
                        " got st=%0d data=%h slot=%0d cnt=%0d"},
                       $realtime, head.op.mode, head.op.key,
                       head.want.status, head.want.data_out, head.want.slot,
                       head.want.count, out_data.status, out_data.data_out,
                       out_data.slot, out_data.count);
          end
        end
      end
      if (in_valid && in_ready) begin
        head.op   = in_data;
        head.want = set_op_result(in_data);
        due_q.push_back(head);
      end
    end
    fail_count  <= fails;
    results_due <= due_q.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives add, get, remove and no-op transfers into the sparse set store with
// random idling on both channels; a checker beside the block predicts and
// compares every result, this module only makes stimulus and the verdict
// ----------------------------------------------------------------------------
module tb
  import sps_pkg::*;
();

  localparam int KEY_SPACE   = 2 ** KEY_WIDTH;
  localparam int RANDOM_OPS  = 1000;
  localparam int QUIET_FROM  = 880;     // no idling from here to the end
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int results_due;
  int cycles = 0;
  int idle_level = 0;     // 0 means no idling, 1..3 raise the odds of a burst
  int stall_left = 0;

  // stimulus-side view of which keys are held, used only to aim operations
  logic live [KEY_SPACE];
  int   live_count = 0;

  sparse_set_packed_store dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sps_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  always #6 clk = ~clk;

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[sparse_set_packed_store] ERROR");
      $finish;
    end
  end

  // receiver side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (idle_level == 0) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) < idle_level) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 14) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // pick a key that is held (or not held); falls back to any key when none fits
  function automatic logic [KEY_WIDTH-1:0] pick_key(logic want_live);
    int start;
    logic [KEY_WIDTH-1:0] k;
    k = KEY_WIDTH'($urandom_range(0, KEY_SPACE - 1));
    if ((want_live && live_count == 0) || (!want_live && live_count == KEY_SPACE))
      return k;
    for (int t = 0; t < 6; t++) begin
      if (live[k] == want_live) return k;
      k = KEY_WIDTH'($urandom_range(0, KEY_SPACE - 1));
    end
    start = $urandom_range(0, KEY_SPACE - 1);
    for (int n = 0; n < KEY_SPACE; n++) begin
      k = KEY_WIDTH'((start + n) % KEY_SPACE);
      if (live[k] == want_live) return k;
    end
    return k;
  endfunction

  // one random operation; the mix shifts from filling, to running full,
  // to draining, to a plain mix, with some noise items in every phase
  function automatic in_item_t random_op(int idx);
    in_item_t op;
    int r, w_new, w_rep, w_get, w_rem;
    if (idx < 400) begin
      w_new = 80; w_rep = 5;  w_get = 8;  w_rem = 4;
    end else if (idx < 550) begin
      w_new = 35; w_rep = 15; w_get = 25; w_rem = 15;
    end else if (idx < 800) begin
      w_new = 5;  w_rep = 5;  w_get = 15; w_rem = 70;
    end else begin
      w_new = 25; w_rep = 10; w_get = 25; w_rem = 25;
    end
    op.data_in = $urandom();
    r = $urandom_range(0, 99);
    if (r < w_new) begin
      op.mode = MODE_ADD;
      op.key  = pick_key(1'b0);
    end else if (r < w_new + w_rep) begin
      op.mode = MODE_ADD;
      op.key  = pick_key(1'b1);
    end else if (r < w_new + w_rep + w_get) begin
      op.mode = MODE_GET;
      op.key  = pick_key(1'b1);
    end else if (r < w_new + w_rep + w_get + w_rem) begin
      op.mode = MODE_REMOVE;
      op.key  = pick_key(1'b1);
    end else begin
      // noise: any mode, any key, mostly misses and no-ops
      op.mode = 2'($urandom_range(0, 3));
      op.key  = KEY_WIDTH'($urandom_range(0, KEY_SPACE - 1));
    end
    return op;
  endfunction

  // hand one item over the input channel; valid holds until the transfer
  task automatic send_op(input in_item_t op);
    int gap;
    case (mode_t'(op.mode))
      MODE_ADD: begin
        if (!live[op.key] && live_count < CAPACITY) begin
          live[op.key] = 1'b1;
          live_count = live_count + 1;
        end
      end
      MODE_REMOVE: begin
        if (live[op.key]) begin
          live[op.key] = 1'b0;
          live_count = live_count - 1;
        end
      end
      default: ;
    endcase
    if (idle_level > 0 && $urandom_range(0, 7) < idle_level) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input mode_t m, input logic [KEY_WIDTH-1:0] k,
                             input logic [DATA_WIDTH-1:0] d);
    in_item_t op;
    op.mode    = m;
    op.key     = k;
    op.data_in = d;
    send_op(op);
  endtask

  initial begin
    foreach (live[k]) live[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_level = 2;
    // empty store: get and remove miss, remove with count zero
    send_fields(MODE_GET,    8'd0,   32'h0000_0000);
    send_fields(MODE_REMOVE, 8'd0,   32'hFFFF_FFFF);
    send_fields(MODE_NOP,    8'd255, 32'hFFFF_FFFF);
    // fill three slots with extreme data
    send_fields(MODE_ADD,    8'd0,   32'h0000_0000);
    send_fields(MODE_ADD,    8'd255, 32'hFFFF_FFFF);
    send_fields(MODE_ADD,    8'h80,  32'hA5A5_5A5A);
    send_fields(MODE_GET,    8'd255, 32'h0000_0000);
    // present key: data replaced in place, maps untouched
    send_fields(MODE_ADD,    8'd0,   32'hFFFF_FFFF);
    send_fields(MODE_GET,    8'd0,   32'h0000_0000);
    send_fields(MODE_ADD,    8'd0,   32'h0000_0000);
    send_fields(MODE_GET,    8'd0,   32'hFFFF_FFFF);
    // remove from the front: last element swaps into slot zero
    send_fields(MODE_REMOVE, 8'd0,   32'h0000_0000);
    send_fields(MODE_GET,    8'h80,  32'h0000_0000);
    send_fields(MODE_GET,    8'd0,   32'h0000_0000);
    send_fields(MODE_REMOVE, 8'd0,   32'h0000_0000);
    send_fields(MODE_REMOVE, 8'h80,  32'h0000_0000);
    send_fields(MODE_GET,    8'd255, 32'h0000_0000);
    // remove of the last element itself, down to empty
    send_fields(MODE_REMOVE, 8'd255, 32'h0000_0000);
    send_fields(MODE_GET,    8'd255, 32'h0000_0000);
    send_fields(MODE_NOP,    8'h7F,  32'h5A5A_A5A5);
    send_fields(MODE_ADD,    8'h7F,  32'h5A5A_A5A5);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      // new idling mix every hundred items, quiet toward the end
      if (i % 100 == 0 || i == QUIET_FROM)
        idle_level = (i >= QUIET_FROM) ? 0 : $urandom_range(0, 3);
      send_op(random_op(i));
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // wait out every predicted result, then keep the clock running for strays
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("[sparse_set_packed_store] OK");
    end else begin
      $display("[sparse_set_packed_store] ERROR");
    end
    $finish;
  end

endmodule
